// ===== rtl/oldq_pkg.sv =====
`timescale 1ns / 1ps

package oldq_pkg;

    // Default list depth
    localparam int CAPACITY_DEF = 16;

    // Field widths
    localparam int DATA_W  = 32;
    localparam int REQ_W   = 3;
    localparam int STAT_W  = 2;
    localparam int COUNT_W = 5;

    // Stream payload widths (packed fields, padded to whole bytes)
    localparam int IN_BITS   = REQ_W + DATA_W;
    localparam int IN_DATA_W = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS   = STAT_W + DATA_W + COUNT_W + DATA_W;
    localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

    typedef logic signed [DATA_W-1:0] data_t;

    // Request codes
    localparam logic [REQ_W-1:0] REQ_ADD_HEAD    = 3'd0;
    localparam logic [REQ_W-1:0] REQ_ADD_TAIL    = 3'd1;
    localparam logic [REQ_W-1:0] REQ_REMOVE_HEAD = 3'd2;
    localparam logic [REQ_W-1:0] REQ_DELETE_KEY  = 3'd3;
    localparam logic [REQ_W-1:0] REQ_FIND_KEY    = 3'd4;

    // Status codes
    localparam logic [STAT_W-1:0] STAT_OK     = 2'd0;
    localparam logic [STAT_W-1:0] STAT_EMPTY  = 2'd1;
    localparam logic [STAT_W-1:0] STAT_FULL   = 2'd2;
    localparam logic [STAT_W-1:0] STAT_ABSENT = 2'd3;

    // Per-cell update
    typedef enum logic [1:0] {
        OP_HOLD,
        OP_LOAD,
        OP_FROM_PREV,
        OP_FROM_NEXT
    } cell_op_t;

    // Control bundle to one cell
    typedef struct packed {
        cell_op_t op;
        logic     cmp_en;
    } cell_ctrl_t;

    // Sequencer states
    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } state_t;

endpackage

// ===== rtl/ordered_list_deque_search.sv =====
`timescale 1ns / 1ps
// A request transfer moves the sequencer to execute; the result is registered on m_tvalid
// when execute finds the result register free. Requests are taken one at a time, as
// s_tready is low in execute: every cell compares the key in the transfer cycle, then the
// row shifts or loads in execute. A waiting result does not block the next request
// transfer; that request executes once the held result transfers. Reset (rst_n low, async):
// list empty, sequencer idle, no result pending; entry contents are undefined until written.

module ordered_list_deque_search #(
    parameter int CAPACITY = oldq_pkg::CAPACITY_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // s_tdata: req_type[2:0], item_value[34:3], zero pad
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [oldq_pkg::IN_DATA_W-1:0]  s_tdata,
    // m_tdata: status[1:0], removed_value[33:2], entry_count[38:34],
    //          front_value[70:39], zero pad
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [oldq_pkg::OUT_DATA_W-1:0] m_tdata
);

    localparam int CW = $clog2(CAPACITY + 1);

    oldq_pkg::state_t state_reg, state_next;

    logic [CW-1:0]                 count_reg, count_next;
    logic [oldq_pkg::REQ_W-1:0]    req_reg;
    oldq_pkg::data_t               item_reg;

    logic                          out_valid_reg, out_valid_next;
    logic [oldq_pkg::STAT_W-1:0]   out_status_reg, stat_next;
    oldq_pkg::data_t               out_removed_reg, removed_next;
    logic [oldq_pkg::COUNT_W-1:0]  out_count_reg;
    oldq_pkg::data_t               out_front_reg, front_next;

    logic                          in_xfer;
    logic                          exec_go;
    logic                          full;
    logic                          empty;
    logic                          any_hit;
    logic [CAPACITY-1:0]           hit;
    logic [CAPACITY-1:0]           at_or_after;
    logic [CAPACITY-1:0]           match;
    oldq_pkg::cell_ctrl_t          ctrl     [CAPACITY];
    oldq_pkg::data_t               vals     [CAPACITY];
    logic [CW+oldq_pkg::COUNT_W-1:0] count_ext;

    assign in_xfer = s_tvalid && s_tready;
    assign exec_go = (state_reg == oldq_pkg::ST_EXEC) && (!out_valid_reg || m_tready);
    assign full    = (count_reg == CW'(CAPACITY));
    assign empty   = (count_reg == '0);

    // Sequencer next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            oldq_pkg::ST_IDLE: if (in_xfer) state_next = oldq_pkg::ST_EXEC;
            oldq_pkg::ST_EXEC: if (exec_go) state_next = oldq_pkg::ST_IDLE;
            default:           state_next = oldq_pkg::ST_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb
    begin
        unique case (state_reg)
            oldq_pkg::ST_IDLE: s_tready = 1'b1;
            default:           s_tready = 1'b0;
        endcase
    end

    // Valid hits and first-match prefix
    always_comb
    begin
        logic run;
        run = 1'b0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            hit[i]         = match[i] && (CW'(i) < count_reg);
            run            = run || hit[i];
            at_or_after[i] = run;
        end
        any_hit = run;
    end

    // Request decode: cell operations, count and status
    always_comb
    begin
        for (int i = 0; i < CAPACITY; i++)
        begin
            ctrl[i].op     = oldq_pkg::OP_HOLD;
            ctrl[i].cmp_en = in_xfer;
        end
        count_next   = count_reg;
        stat_next    = oldq_pkg::STAT_OK;
        removed_next = '0;
        unique case (req_reg)
            oldq_pkg::REQ_ADD_HEAD:
            begin
                if (full)
                begin
                    stat_next = oldq_pkg::STAT_FULL;
                end
                else
                begin
                    ctrl[0].op = oldq_pkg::OP_LOAD;
                    for (int i = 1; i < CAPACITY; i++)
                    begin
                        ctrl[i].op = oldq_pkg::OP_FROM_PREV;
                    end
                    count_next = count_reg + 1'b1;
                end
            end
            oldq_pkg::REQ_ADD_TAIL:
            begin
                if (full)
                begin
                    stat_next = oldq_pkg::STAT_FULL;
                end
                else
                begin
                    for (int i = 0; i < CAPACITY; i++)
                    begin
                        if (CW'(i) == count_reg)
                        begin
                            ctrl[i].op = oldq_pkg::OP_LOAD;
                        end
                    end
                    count_next = count_reg + 1'b1;
                end
            end
            oldq_pkg::REQ_REMOVE_HEAD:
            begin
                if (empty)
                begin
                    stat_next = oldq_pkg::STAT_EMPTY;
                end
                else
                begin
                    removed_next = vals[0];
                    for (int i = 0; i < CAPACITY; i++)
                    begin
                        ctrl[i].op = oldq_pkg::OP_FROM_NEXT;
                    end
                    count_next = count_reg - 1'b1;
                end
            end
            oldq_pkg::REQ_DELETE_KEY:
            begin
                if (empty)
                begin
                    stat_next = oldq_pkg::STAT_EMPTY;
                end
                else if (!any_hit)
                begin
                    stat_next = oldq_pkg::STAT_ABSENT;
                end
                else
                begin
                    // close the gap from the first match toward the tail
                    for (int i = 0; i < CAPACITY; i++)
                    begin
                        if (at_or_after[i])
                        begin
                            ctrl[i].op = oldq_pkg::OP_FROM_NEXT;
                        end
                    end
                    count_next = count_reg - 1'b1;
                end
            end
            oldq_pkg::REQ_FIND_KEY:
            begin
                if (!any_hit)
                begin
                    stat_next = oldq_pkg::STAT_ABSENT;
                end
            end
            default:
            begin
                stat_next = oldq_pkg::STAT_OK;
            end
        endcase
        if (!exec_go)
        begin
            for (int i = 0; i < CAPACITY; i++)
            begin
                ctrl[i].op = oldq_pkg::OP_HOLD;
            end
        end
    end

    // Head value after the update
    always_comb
    begin
        if (count_next == '0)
        begin
            front_next = '0;
        end
        else
        begin
            case (ctrl[0].op)
                oldq_pkg::OP_LOAD:      front_next = item_reg;
                oldq_pkg::OP_FROM_NEXT: front_next = vals[1];
                default:                front_next = vals[0];
            endcase
        end
    end

    assign count_ext = {{oldq_pkg::COUNT_W{1'b0}}, count_next};

    // Row of cells
    for (genvar g = 0; g < CAPACITY; g++)
    begin : g_cell
        oldq_pkg::data_t prev_v;
        oldq_pkg::data_t next_v;
        if (g == 0)
        begin : g_first
            assign prev_v = item_reg;
        end
        else
        begin : g_mid
            assign prev_v = vals[g-1];
        end
        if (g == CAPACITY - 1)
        begin : g_last
            assign next_v = vals[g];
        end
        else
        begin : g_inner
            assign next_v = vals[g+1];
        end
        oldq_cell u_cell (
            .clk        (clk),
            .ctrl       (ctrl[g]),
            .cmp_key    (s_tdata[oldq_pkg::REQ_W +: oldq_pkg::DATA_W]),
            .load_value (item_reg),
            .prev_value (prev_v),
            .next_value (next_v),
            .value      (vals[g]),
            .match      (match[g])
        );
    end

    // Result register handshake
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (exec_go)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= oldq_pkg::ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (exec_go)
            begin
                count_reg <= count_next;
            end
        end
    end

    // Request and result payload
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            req_reg  <= s_tdata[oldq_pkg::REQ_W-1:0];
            item_reg <= s_tdata[oldq_pkg::REQ_W +: oldq_pkg::DATA_W];
        end
        if (exec_go)
        begin
            out_status_reg  <= stat_next;
            out_removed_reg <= removed_next;
            out_count_reg   <= count_ext[oldq_pkg::COUNT_W-1:0];
            out_front_reg   <= front_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(oldq_pkg::OUT_DATA_W - oldq_pkg::OUT_BITS){1'b0}},
                       out_front_reg, out_count_reg, out_removed_reg, out_status_reg};

    // Checks
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(CAPACITY))
        else $error("entry count above capacity");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> (count_reg == $past(count_reg)) || (count_reg == $past(count_reg) + 1'b1)
                 || (count_reg + 1'b1 == $past(count_reg)))
        else $error("entry count moved by more than one");

    a_xfer_exec: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> (state_reg == oldq_pkg::ST_EXEC))
        else $error("request transfer not followed by execute");

    a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == oldq_pkg::ST_EXEC))
        else $error("result raised outside execute");

endmodule

// ===== rtl/oldq_cell.sv =====
`timescale 1ns / 1ps

module oldq_cell (
    input  logic                clk,
    input  oldq_pkg::cell_ctrl_t ctrl,
    input  oldq_pkg::data_t     cmp_key,     // key compared at request transfer
    input  oldq_pkg::data_t     load_value,  // value written on insert
    input  oldq_pkg::data_t     prev_value,  // neighbor toward head
    input  oldq_pkg::data_t     next_value,  // neighbor toward tail
    output oldq_pkg::data_t     value,
    output logic                match
);

    oldq_pkg::data_t value_reg;
    oldq_pkg::data_t value_next;
    logic            match_reg;

    // Entry select
    always_comb
    begin
        case (ctrl.op)
            oldq_pkg::OP_LOAD:      value_next = load_value;
            oldq_pkg::OP_FROM_PREV: value_next = prev_value;
            oldq_pkg::OP_FROM_NEXT: value_next = next_value;
            default:                value_next = value_reg;
        endcase
    end

    // Entry and compare flag, payload only
    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
        if (ctrl.cmp_en)
        begin
            match_reg <= (value_reg == cmp_key);
        end
    end

    assign value = value_reg;
    assign match = match_reg;

endmodule
